FILE: sv/sss_pkg.sv
// Shared types, constants and the segment decode for the seven-segment scanner.
// No dependencies; every other file imports this package.
package sss_pkg;

   localparam int MAX_DIGITS     = 8;
   localparam int DIGITS_DEFAULT = 8;
   localparam int VALUE_W        = 27;
   localparam int POINT_W        = 4;
   localparam int ADDR_W         = 3;
   localparam int BCD_W          = 4;
   localparam int SEG_W          = 7;

   // Reciprocal of ten for exact floor division of values below 2^32
   localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
   localparam int          RECIP_SH  = 35;

   // Word moving down the conversion chain
   typedef struct packed {
      logic [VALUE_W-1:0]                rest;
      logic [POINT_W-1:0]                point;
      logic [MAX_DIGITS-1:0][BCD_W-1:0]  digits;
   } sss_item_type;

   // Segment pattern of one decimal digit, bit 0 is segment a, bit 6 is segment g
   function automatic logic [SEG_W-1:0] seg_bits(input logic [BCD_W-1:0] digit);
      logic [SEG_W-1:0] seg;
      case (digit)
         4'd0:    seg = 7'b0111111;
         4'd1:    seg = 7'b0000110;
         4'd2:    seg = 7'b1011011;
         4'd3:    seg = 7'b1001111;
         4'd4:    seg = 7'b1100110;
         4'd5:    seg = 7'b1101101;
         4'd6:    seg = 7'b1111101;
         4'd7:    seg = 7'b0000111;
         4'd8:    seg = 7'b1111111;
         4'd9:    seg = 7'b1101111;
         default: seg = 7'b0000000;
      endcase
      return seg;
   endfunction

endpackage

FILE: sv/sss_if.sv
// Valid/ready channel interfaces for the scanner's request and response words.
// Depends on sss_pkg for field widths.
interface sss_req_if import sss_pkg::*;;
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] value;
   logic [POINT_W-1:0] point_position;

   modport source (output valid, value, point_position, input ready);
   modport sink   (input valid, value, point_position, output ready);
endinterface

interface sss_rsp_if import sss_pkg::*;;
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] digit_address;
   logic              serial_bit;
   logic              latch_after;
   logic              last;

   modport source (output valid, digit_address, serial_bit, latch_after, last, input ready);
   modport sink   (input valid, digit_address, serial_bit, latch_after, last, output ready);
endinterface

FILE: sv/sss_cell.sv
// One cell of the binary-to-decimal chain: peels off one decimal digit per word.
// Depends on sss_pkg.
module sss_cell import sss_pkg::*; #(
   parameter int INDEX = 0
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  logic         in_valid,
   input  sss_item_type in_item,
   output logic         out_valid,
   output sss_item_type out_item
);

   localparam logic [ADDR_W-1:0] SLOT = ADDR_W'(INDEX);

   logic               valid_ff;
   sss_item_type       item_ff;
   sss_item_type       item_in;
   logic [63:0]        prod;
   logic [VALUE_W-1:0] quot;
   logic [VALUE_W-1:0] times_ten;
   logic [VALUE_W-1:0] remainder;

   // Divide the remaining value by ten through the reciprocal
   always_comb begin
      prod      = {{(32-VALUE_W){1'b0}}, in_item.rest} * RECIP_TEN;
      quot      = VALUE_W'(prod >> RECIP_SH);
      times_ten = (quot << 3) + (quot << 1);
      remainder = in_item.rest - times_ten;
      item_in   = in_item;
      item_in.rest         = quot;
      item_in.digits[SLOT] = remainder[BCD_W-1:0];
   end

   // Hand the word to the next cell whenever the chain advances
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

FILE: sv/sss_serializer.sv
// Bit serializer: walks the decoded digits and emits one segment bit per word.
// Depends on sss_pkg.
module sss_serializer import sss_pkg::*; #(
   parameter int DIGITS = DIGITS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  sss_item_type  in_item,
   output logic          load,
   sss_rsp_if.source     rsp_ch
);

   localparam logic [ADDR_W-1:0] LAST_DIGIT = ADDR_W'(DIGITS - 1);
   localparam logic [2:0]        LAST_BIT   = 3'd7;
   localparam logic [ADDR_W-1:0] TOP_ADDR   = ADDR_W'(MAX_DIGITS - 1);

   logic                              busy_ff;
   logic [ADDR_W-1:0]                 digit_cnt_ff;
   logic [2:0]                        bit_cnt_ff;
   logic [MAX_DIGITS-1:0][BCD_W-1:0]  digits_ff;
   logic [POINT_W-1:0]                point_ff;
   logic                              fire;
   logic                              end_digit;
   logic                              end_scan;
   logic [SEG_W-1:0]                  seg;
   logic                              dp;
   logic [SEG_W:0]                    seg_row;

   // Decode the current position
   always_comb begin
      fire      = busy_ff & rsp_ch.ready;
      end_digit = (bit_cnt_ff == LAST_BIT);
      end_scan  = end_digit & (digit_cnt_ff == LAST_DIGIT);
      load      = in_valid & (~busy_ff | (fire & end_scan));
      seg       = seg_bits(digits_ff[digit_cnt_ff]);
      dp        = (point_ff == ({1'b0, digit_cnt_ff} + 4'd1));
      seg_row   = {dp, seg};
   end

   // Advance through bits and digits, take the next scan at the end
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         digit_cnt_ff <= '0;
         bit_cnt_ff   <= '0;
      end else if (load) begin
         busy_ff      <= 1'b1;
         digit_cnt_ff <= '0;
         bit_cnt_ff   <= '0;
      end else if (fire) begin
         if (end_scan) begin
            busy_ff <= 1'b0;
         end
         bit_cnt_ff <= bit_cnt_ff + 3'd1;
         if (end_digit) begin
            digit_cnt_ff <= digit_cnt_ff + ADDR_W'(1);
         end
      end
      if (load) begin
         digits_ff <= in_item.digits;
         point_ff  <= in_item.point;
      end
   end

   assign rsp_ch.valid         = busy_ff;
   assign rsp_ch.digit_address = TOP_ADDR - digit_cnt_ff;
   assign rsp_ch.serial_bit    = seg_row[bit_cnt_ff];
   assign rsp_ch.latch_after   = end_digit;
   assign rsp_ch.last          = end_scan;

endmodule

FILE: sv/seven_segment_serial_scanner.sv
// Seven-segment serial scanner. Each request word (a binary value and a point
// position) becomes one refresh scan of 8*DIGITS response words, 64 at the
// default of eight digits: for each digit, least significant first, the decoder
// address (7 minus the digit index) and eight segment bits a..g, dp, with the
// latch flag on the eighth. The serializer emits one response word per cycle
// while rsp_ch.ready is high, and can start the next scan as soon as the last
// word of the current one is taken. A request passes a chain of DIGITS cells,
// one decimal digit per cell and cycle while the chain advances, before its scan
// starts; the chain takes a new request while the current scan is going out.
module seven_segment_serial_scanner import sss_pkg::*; #(
   parameter int DIGITS = DIGITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   sss_req_if.sink   req_ch,
   sss_rsp_if.source rsp_ch
);

   logic                      load;
   logic                      advance;
   logic         [DIGITS:0]   chain_valid;
   sss_item_type [DIGITS:0]   chain_item;

   // Feed the head of the chain from the request channel
   assign chain_valid[0] = req_ch.valid;
   assign chain_item[0]  = '{rest:   req_ch.value,
                             point:  req_ch.point_position,
                             digits: '0};

   // Move the whole chain unless its tail word is waiting for the serializer
   assign advance      = ~chain_valid[DIGITS] | load;
   assign req_ch.ready = advance;

   for (genvar i = 0; i < DIGITS; i++) begin : g_cell
      sss_cell #(.INDEX(i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (chain_valid[i]),
         .in_item   (chain_item[i]),
         .out_valid (chain_valid[i+1]),
         .out_item  (chain_item[i+1])
      );
   end

   sss_serializer #(.DIGITS(DIGITS)) u_ser (
      .clock    (clock),
      .reset    (reset),
      .in_valid (chain_valid[DIGITS]),
      .in_item  (chain_item[DIGITS]),
      .load     (load),
      .rsp_ch   (rsp_ch)
   );

endmodule

FILE: sv/sss_checker.sv
// Port-level checks on the scanner's response stream, bound to the top level.
// Depends on sss_pkg for widths.
module sss_checker import sss_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [ADDR_W-1:0] rsp_digit_address,
   input logic              rsp_latch_after,
   input logic              rsp_last
);

   // Hold a stalled word
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped while stalled");

   // End a scan only on a digit boundary
   a_last_latch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_latch_after)
      else $error("scan ended inside a digit");

   // Keep the address within a digit
   a_mid_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_latch_after |=>
         rsp_valid && $stable(rsp_digit_address))
      else $error("digit interrupted or address changed mid digit");

   // Step the address down by one between digits of a scan
   a_next_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_latch_after && !rsp_last |=>
         rsp_valid && (rsp_digit_address == ADDR_W'($past(rsp_digit_address) - 1'b1)))
      else $error("digit address did not step down");

endmodule

bind seven_segment_serial_scanner sss_checker u_sss_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_digit_address (rsp_ch.digit_address),
   .rsp_latch_after   (rsp_ch.latch_after),
   .rsp_last          (rsp_ch.last)
);
